FILE: sv/priority_ready_queue_assert.svh
// ----------------------------------------------------------------------------
// priority_ready_queue_assert
// Assertion macros of the ready queue RTL. Each macro asserts one implication,
// sampled on the rising clock edge and disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define PRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types, codes and default sizes of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int DEF_MAX_TASKS    = 64;
  localparam int DEF_LEVELS       = 16;
  localparam int DEF_CONTEXT_BITS = 32;

  // Fixed widths of the item fields.
  localparam int PRIO_W   = 4;
  localparam int ID_W     = 6;
  localparam int OUT_CTX_W = 32;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_PRIO = 2'd3
  } status_t;

  // Per-level cell control.
  typedef struct packed {
    logic look;        // this level is the one named by the pending push
    logic push_en;     // link a new slot at the tail
    logic pop_en;      // retire the head of this level
    logic pop_single;  // the retired head was the only entry
  } cell_cmd_t;

  // Slot store control.
  typedef struct packed {
    logic wr;    // write context and level of a new slot
    logic link;  // write the next pointer of the old tail
    logic rd;    // read a slot for a pop
  } mem_cmd_t;

endpackage

FILE: sv/prq_level_cell.sv
// ----------------------------------------------------------------------------
// prq_level_cell
// One priority level: head, tail and non-empty flag, plus the chain logic
// that picks the most urgent non-empty level and looks up a push tail.
// ----------------------------------------------------------------------------
module prq_level_cell #(
  parameter int SLOT_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prq_pkg::cell_cmd_t cmd,
  input  logic [SLOT_W-1:0] new_slot,
  input  logic [SLOT_W-1:0] next_slot,
  input  logic              taken_in,
  input  logic [SLOT_W-1:0] head_in,
  input  logic              single_in,
  input  logic              hit_in,
  input  logic [SLOT_W-1:0] tail_in,
  output logic              taken_out,
  output logic [SLOT_W-1:0] head_out,
  output logic              single_out,
  output logic              hit_out,
  output logic [SLOT_W-1:0] tail_out,
  output logic              win
);
  import prq_pkg::*;

  logic              nonempty_r, nonempty_nxt;
  logic [SLOT_W-1:0] first_r, first_nxt;
  logic [SLOT_W-1:0] last_r, last_nxt;

  // A more urgent level below this one blocks it from winning.
  assign win        = nonempty_r & ~taken_in;
  assign taken_out  = taken_in | nonempty_r;
  assign head_out   = head_in | (win ? first_r : '0);
  assign single_out = single_in | (win & (first_r == last_r));
  assign hit_out    = hit_in | (cmd.look & nonempty_r);
  assign tail_out   = tail_in | (cmd.look ? last_r : '0);

  always_comb begin
    nonempty_nxt = nonempty_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    if (cmd.push_en) begin
      if (!nonempty_r) begin
        first_nxt    = new_slot;
        nonempty_nxt = 1'b1;
      end
      last_nxt = new_slot;
    end else if (cmd.pop_en) begin
      if (cmd.pop_single) begin
        nonempty_nxt = 1'b0;
      end else begin
        first_nxt = next_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= 1'b0;
    end else begin
      nonempty_r <= nonempty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

endmodule

FILE: sv/prq_slot_mem.sv
// ----------------------------------------------------------------------------
// prq_slot_mem
// Task slot store: context word, level and next link of every slot, with a
// registered read port shared by all three arrays.
// ----------------------------------------------------------------------------
module prq_slot_mem #(
  parameter int SLOTS  = 64,
  parameter int SLOT_W = 6,
  parameter int LVL_W  = 4,
  parameter int CTX_W  = 32
) (
  input  logic              clk,
  input  prq_pkg::mem_cmd_t cmd,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [CTX_W-1:0]  wr_ctx,
  input  logic [LVL_W-1:0]  wr_lvl,
  input  logic [SLOT_W-1:0] link_addr,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [CTX_W-1:0]  rd_ctx,
  output logic [LVL_W-1:0]  rd_lvl,
  output logic [SLOT_W-1:0] rd_next
);
  import prq_pkg::*;

  logic [CTX_W-1:0]  ctx_mem  [SLOTS];
  logic [LVL_W-1:0]  lvl_mem  [SLOTS];
  logic [SLOT_W-1:0] next_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ctx_mem[wr_slot] <= wr_ctx;
      lvl_mem[wr_slot] <= wr_lvl;
    end
    // The new slot becomes the successor of the old tail.
    if (cmd.link) begin
      next_mem[link_addr] <= wr_slot;
    end
    if (cmd.rd) begin
      rd_ctx  <= ctx_mem[rd_addr];
      rd_lvl  <= lvl_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
    end
  end

endmodule

FILE: sv/priority_ready_queue.sv
// ----------------------------------------------------------------------------
// priority_ready_queue
// Task ready queue with one FIFO per priority level, level 0 most urgent.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. in_kind selects a push
// (in_priority_req, in_context_req) or a pop of the oldest task of the most
// urgent non-empty level. Every item gives exactly one result, shown for one
// cycle with out_valid high; the receiver cannot stall the block.
// A push, and a pop of an empty queue, deliver their result in the cycle
// after acceptance and leave busy low, so one may be taken every cycle.
// A pop that finds a task reads the slot store through its registered read
// port, holds busy for one cycle so no other item is taken meanwhile, and
// delivers its result from the read register through the output register;
// the read returns the successor link needed to advance the level's head.
// Slots are handed out in ascending order and are never reused, so at most
// MAX_TASKS pushes succeed; later pushes with a valid priority report full.
// The level cells form a chain that finds the most urgent non-empty level and
// the tail of the level being pushed.
// Reset empties all levels and the slot count and needs no clearing pass.
// ----------------------------------------------------------------------------
module priority_ready_queue #(
  parameter int MAX_TASKS    = prq_pkg::DEF_MAX_TASKS,
  parameter int LEVELS       = prq_pkg::DEF_LEVELS,
  parameter int CONTEXT_BITS = prq_pkg::DEF_CONTEXT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [prq_pkg::PRIO_W-1:0]      in_priority_req,
  input  logic [prq_pkg::OUT_CTX_W-1:0]   in_context_req,
  output logic                            out_valid,
  output prq_pkg::status_t                out_status,
  output logic [prq_pkg::ID_W-1:0]        out_task_id,
  output logic [prq_pkg::PRIO_W-1:0]      out_task_priority,
  output logic [prq_pkg::OUT_CTX_W-1:0]   out_task_context
);
  import prq_pkg::*;

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int LVL_W  = $clog2(LEVELS);

  // Chain taps between level cells.
  logic              taken  [LEVELS+1];
  logic [SLOT_W-1:0] head   [LEVELS+1];
  logic              single [LEVELS+1];
  logic              hit    [LEVELS+1];
  logic [SLOT_W-1:0] tail   [LEVELS+1];
  logic [LEVELS-1:0] win_vec;

  logic                  accept, is_pop, bad_prio, full, push_ok, pop_go;
  logic [LVL_W+PRIO_W-1:0] prio_ext;
  logic [LVL_W-1:0]      prio_idx;
  logic [SLOT_W-1:0]     new_slot;
  logic [CONTEXT_BITS+OUT_CTX_W-1:0] in_ctx_ext;
  mem_cmd_t              mem_cmd;

  logic [CONTEXT_BITS-1:0] rd_ctx;
  logic [LVL_W-1:0]        rd_lvl;
  logic [SLOT_W-1:0]       rd_next;

  logic              pop_pend_r;
  logic [LEVELS-1:0] win_r;
  logic              single_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  slots_used_r, slots_used_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [PRIO_W-1:0]    out_prio_r, out_prio_nxt;
  logic [OUT_CTX_W-1:0] out_ctx_r, out_ctx_nxt;

  logic [SLOT_W+ID_W-1:0]          id_new_ext, id_pop_ext;
  logic [LVL_W+PRIO_W-1:0]         lvl_pop_ext;
  logic [CONTEXT_BITS+OUT_CTX_W-1:0] ctx_pop_ext;

  assign busy     = pop_pend_r;
  assign accept   = start & ~busy;
  assign is_pop   = (in_kind == KIND_POP);
  assign prio_ext = {{LVL_W{1'b0}}, in_priority_req};
  assign prio_idx = prio_ext[LVL_W-1:0];
  assign bad_prio = (prio_ext >= (LVL_W+PRIO_W)'(LEVELS));
  assign full     = (slots_used_r == CNT_W'(MAX_TASKS));
  assign new_slot = slots_used_r[SLOT_W-1:0];
  assign push_ok  = accept & ~is_pop & ~bad_prio & ~full;
  assign pop_go   = accept & is_pop & taken[LEVELS];
  assign in_ctx_ext = {{CONTEXT_BITS{1'b0}}, in_context_req};

  assign taken[0]  = 1'b0;
  assign head[0]   = '0;
  assign single[0] = 1'b0;
  assign hit[0]    = 1'b0;
  assign tail[0]   = '0;

  for (genvar i = 0; i < LEVELS; i++) begin : g_level
    cell_cmd_t cmd;

    always_comb begin
      cmd.look       = (prio_idx == LVL_W'(i));
      cmd.push_en    = push_ok & cmd.look;
      cmd.pop_en     = pop_pend_r & win_r[i];
      cmd.pop_single = single_r;
    end

    prq_level_cell #(
      .SLOT_W(SLOT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_slot  (new_slot),
      .next_slot (rd_next),
      .taken_in  (taken[i]),
      .head_in   (head[i]),
      .single_in (single[i]),
      .hit_in    (hit[i]),
      .tail_in   (tail[i]),
      .taken_out (taken[i+1]),
      .head_out  (head[i+1]),
      .single_out(single[i+1]),
      .hit_out   (hit[i+1]),
      .tail_out  (tail[i+1]),
      .win       (win_vec[i])
    );
  end

  always_comb begin
    mem_cmd.wr   = push_ok;
    mem_cmd.link = push_ok & hit[LEVELS];
    mem_cmd.rd   = pop_go;
  end

  prq_slot_mem #(
    .SLOTS (MAX_TASKS),
    .SLOT_W(SLOT_W),
    .LVL_W (LVL_W),
    .CTX_W (CONTEXT_BITS)
  ) u_mem (
    .clk      (clk),
    .cmd      (mem_cmd),
    .wr_slot  (new_slot),
    .wr_ctx   (in_ctx_ext[CONTEXT_BITS-1:0]),
    .wr_lvl   (prio_idx),
    .link_addr(tail[LEVELS]),
    .rd_addr  (head[LEVELS]),
    .rd_ctx   (rd_ctx),
    .rd_lvl   (rd_lvl),
    .rd_next  (rd_next)
  );

  assign id_new_ext  = {{ID_W{1'b0}}, new_slot};
  assign id_pop_ext  = {{ID_W{1'b0}}, slot_r};
  assign lvl_pop_ext = {{PRIO_W{1'b0}}, rd_lvl};
  assign ctx_pop_ext = {{OUT_CTX_W{1'b0}}, rd_ctx};

  always_comb begin
    slots_used_nxt = slots_used_r;
    if (push_ok) begin
      slots_used_nxt = slots_used_r + CNT_W'(1);
    end
  end

  // A pop that found a task finishes from the slot store; everything else
  // has its result formed in the cycle it is taken.
  always_comb begin
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_id_nxt     = '0;
    out_prio_nxt   = '0;
    out_ctx_nxt    = '0;
    if (pop_pend_r) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = id_pop_ext[ID_W-1:0];
      out_prio_nxt  = lvl_pop_ext[PRIO_W-1:0];
      out_ctx_nxt   = ctx_pop_ext[OUT_CTX_W-1:0];
    end else if (accept && !pop_go) begin
      out_valid_nxt = 1'b1;
      if (is_pop) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        out_prio_nxt = in_priority_req;
        if (bad_prio) begin
          out_status_nxt = ST_BAD_PRIO;
        end else if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_id_nxt = id_new_ext[ID_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_pend_r   <= 1'b0;
      slots_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pop_pend_r   <= pop_go;
      slots_used_r <= slots_used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      win_r    <= win_vec;
      single_r <= single[LEVELS];
      slot_r   <= head[LEVELS];
    end
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_prio_r   <= out_prio_nxt;
    out_ctx_r    <= out_ctx_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_task_id       = out_id_r;
  assign out_task_priority = out_prio_r;
  assign out_task_context  = out_ctx_r;

`include "priority_ready_queue_assert.svh"

  `PRQ_ASSERT_NOW(a_one_winner, 1'b1, $onehot0(win_vec), "more than one level won the pop")
  `PRQ_ASSERT_NOW(a_count_bound, 1'b1, slots_used_r <= CNT_W'(MAX_TASKS), "slot count overran")
  `PRQ_ASSERT_NEXT(a_pop_result, pop_pend_r, out_valid && out_status == ST_OK, "pop lost result")
  `PRQ_ASSERT_NEXT(a_push_count, push_ok, slots_used_r == $past(slots_used_r) + CNT_W'(1), "push count")

endmodule
